/* rtl/bfp_pkg.sv */
`timescale 1ns / 1ps
package bfp_pkg;

	localparam int VTX_W      = 6;
	localparam int PRED_W     = 7;
	localparam int WIN_W      = 16;
	localparam int NVR_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

	localparam logic [NVR_W-1:0]  NV_RESET  = 7'd64;
	localparam logic [VTX_W-1:0]  SRC_RESET = '0;
	localparam logic [PRED_W-1:0] PRED_NONE = '1;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic start;
		logic edge_rd;
		logic dist_rd;
		logic relax;
		logic vtx_rd;
		logic vtx_ld;
		logic cyc_ld;
	} bfp_cmd_t;

	// status back to the sequencer
	typedef struct packed {
		logic pass_end;
		logic check;
		logic improve;
		logic last_vtx;
		logic out_free;
	} bfp_stat_t;

endpackage

/* rtl/bellman_ford_predecessors.sv */
`timescale 1ns / 1ps
// edges load at one item per cycle while idle; the item with tlast starts a run
// a run visits each stored edge in up to nv passes, in three steps per visit
// (edge memory read, distance memory read, add and compare with write-back),
// then reads each result from the predecessor memory into the output register
// arst_n clears state, edge count, reached flags and config (64 vertices, source 0)
module bellman_ford_predecessors import bfp_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // from_vertex, to_vertex, edge_weight, zero pad
	input  logic                  s_tlast,   // last_edge
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // vertex_index, predecessor, zero pad
	output logic                  m_tuser,   // negative_cycle
	output logic                  m_tlast    // last_result
);

	bfp_cmd_t          cmd;
	bfp_stat_t         stat;
	logic [VTX_W-1:0]  out_vtx;
	logic [PRED_W-1:0] out_pred;

	bfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bfp_dpath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_from   (s_tdata[VTX_W-1:0]),
		.in_to     (s_tdata[2*VTX_W-1:VTX_W]),
		.in_weight (s_tdata[2*VTX_W+WIN_W-1:2*VTX_W]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_vtx   (out_vtx),
		.out_pred  (out_pred),
		.out_neg   (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W - VTX_W - PRED_W){1'b0}}, out_pred, out_vtx};

endmodule

/* rtl/bfp_ctrl.sv */
`timescale 1ns / 1ps
module bfp_ctrl import bfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tlast,
	output logic      s_tready,
	output bfp_cmd_t  cmd,
	input  bfp_stat_t stat
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_START   = 3'd1;
	localparam logic [2:0] ST_RD_EDGE = 3'd2;
	localparam logic [2:0] ST_RD_DIST = 3'd3;
	localparam logic [2:0] ST_EVAL    = 3'd4;
	localparam logic [2:0] ST_CYC     = 3'd5;
	localparam logic [2:0] ST_OUT_RD  = 3'd6;
	localparam logic [2:0] ST_OUT_LD  = 3'd7;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_RD_EDGE;
			end
			ST_RD_EDGE: begin
				cmd.edge_rd = 1'b1;
				state_d     = ST_RD_DIST;
			end
			ST_RD_DIST: begin
				cmd.dist_rd = 1'b1;
				state_d     = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.relax = 1'b1;
				if (stat.check && stat.improve) begin
					state_d = ST_CYC;
				end else if (stat.pass_end && stat.check) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_RD_EDGE;
				end
			end
			ST_CYC: begin
				if (stat.out_free) begin
					cmd.cyc_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_OUT_RD: begin
				if (stat.out_free) begin
					cmd.vtx_rd = 1'b1;
					state_d    = ST_OUT_LD;
				end
			end
			ST_OUT_LD: begin
				cmd.vtx_ld = 1'b1;
				state_d    = stat.last_vtx ? ST_IDLE : ST_OUT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/bfp_dpath.sv */
`timescale 1ns / 1ps
module bfp_dpath import bfp_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [VTX_W-1:0]      in_from,
	input  logic [VTX_W-1:0]      in_to,
	input  logic [WIN_W-1:0]      in_weight,
	input  bfp_cmd_t              cmd,
	output bfp_stat_t             stat,
	input  logic                  m_tready,
	output logic                  out_valid,
	output logic [VTX_W-1:0]      out_vtx,
	output logic [PRED_W-1:0]     out_pred,
	output logic                  out_neg,
	output logic                  out_last
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NVW = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	// longest walk is nv * edges steps of one weight each
	localparam int DW  = WEIGHT_BITS + VW + ECW + 1;
	localparam int EDW = 2 * VTX_W + WEIGHT_BITS;

	// configuration
	logic [NVR_W-1:0] nv_raw_q;
	logic [VTX_W-1:0] src_q;
	logic [NVW-1:0]   nv_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_raw_q <= NV_RESET;
			src_q    <= SRC_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_NUM_VERTICES:  nv_raw_q <= cfg_wdata[NVR_W-1:0];
				REG_SOURCE_VERTEX: src_q    <= cfg_wdata[VTX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (nv_raw_q == '0) begin
			nv_eff = NVW'(1);
		end else if (32'(nv_raw_q) > 32'(MAX_VERTICES)) begin
			nv_eff = NVW'(MAX_VERTICES);
		end else begin
			nv_eff = NVW'(nv_raw_q);
		end
	end

	// low weight bits of the field; zero extended when WEIGHT_BITS is wider than the field
	logic signed [WEIGHT_BITS-1:0] w_in;
	generate
		if (WEIGHT_BITS <= WIN_W) begin : g_w_narrow
			assign w_in = in_weight[WEIGHT_BITS-1:0];
		end else begin : g_w_wide
			assign w_in = {{(WEIGHT_BITS - WIN_W){1'b0}}, in_weight};
		end
	endgenerate

	// edge list
	logic [EDW-1:0] edge_mem [MAX_EDGES];
	logic [EDW-1:0] edata_q;
	logic [ECW-1:0] edge_cnt_q;
	logic           store_ok;
	logic           finish;

	assign store_ok = cmd.load && (32'(edge_cnt_q) < 32'(MAX_EDGES));
	assign finish   = cmd.cyc_ld || (cmd.vtx_ld && stat.last_vtx);

	always_ff @(posedge clk) begin
		if (store_ok) begin
			edge_mem[edge_cnt_q[EAW-1:0]] <= {w_in, in_to, in_from};
		end
	end

	logic [ECW-1:0] e_q;
	logic [NVW-1:0] pass_q;
	logic [VW-1:0]  v_q;

	always_ff @(posedge clk) begin
		if (cmd.edge_rd) begin
			edata_q <= edge_mem[e_q[EAW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
		end else if (finish) begin
			edge_cnt_q <= '0;
		end else if (store_ok) begin
			edge_cnt_q <= edge_cnt_q + ECW'(1);
		end
	end

	// loop counters: edge, pass, reported vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q    <= '0;
			pass_q <= '0;
			v_q    <= '0;
		end else begin
			if (cmd.start) begin
				e_q    <= '0;
				pass_q <= NVW'(1);
				v_q    <= '0;
			end
			if (cmd.relax) begin
				if (stat.pass_end) begin
					e_q <= '0;
					if (!stat.check) begin
						pass_q <= pass_q + NVW'(1);
					end
				end else begin
					e_q <= e_q + ECW'(1);
				end
			end
			if (cmd.vtx_ld) begin
				v_q <= v_q + VW'(1);
			end
		end
	end

	assign stat.pass_end = (32'(e_q) + 32'd1 == 32'(edge_cnt_q));
	assign stat.check    = (pass_q == nv_eff);
	assign stat.last_vtx = (32'(v_q) + 32'd1 == 32'(nv_eff));

	// edge under relaxation
	logic [VTX_W-1:0]              from_s, to_s;
	logic signed [WEIGHT_BITS-1:0] w_s;
	logic signed [DW-1:0]          df_q, dt_q, cand;
	logic signed [DW-1:0]          dist_mem [MAX_VERTICES];
	logic [VTX_W-1:0]              pred_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]       reached_q, pvalid_q;
	logic [VW-1:0]                 fi, ti, src_idx;
	logic                          in_rng, src_ok, do_apply;

	always_ff @(posedge clk) begin
		if (cmd.dist_rd) begin
			from_s <= edata_q[VTX_W-1:0];
			to_s   <= edata_q[2*VTX_W-1:VTX_W];
			w_s    <= edata_q[EDW-1:2*VTX_W];
			df_q   <= dist_mem[VW'(edata_q[VTX_W-1:0])];
			dt_q   <= dist_mem[VW'(edata_q[2*VTX_W-1:VTX_W])];
		end
	end

	assign fi      = VW'(from_s);
	assign ti      = VW'(to_s);
	assign src_idx = VW'(src_q);
	assign src_ok  = (32'(src_q) < 32'(nv_eff));
	assign in_rng  = (32'(from_s) < 32'(nv_eff)) && (32'(to_s) < 32'(nv_eff));
	assign cand    = df_q + {{(DW - WEIGHT_BITS){w_s[WEIGHT_BITS-1]}}, w_s};

	// unreached target counts as infinitely far
	assign stat.improve = in_rng && reached_q[fi] && (!reached_q[ti] || (cand < dt_q));
	assign do_apply     = cmd.relax && !stat.check && stat.improve;

	always_ff @(posedge clk) begin
		if (cmd.start && src_ok) begin
			dist_mem[src_idx] <= '0;
		end else if (do_apply) begin
			dist_mem[ti] <= cand;
		end
	end

	always_ff @(posedge clk) begin
		if (do_apply) begin
			pred_mem[ti] <= from_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
			pvalid_q  <= '0;
		end else if (cmd.start) begin
			// only the source starts out reached, if it is in range
			reached_q <= src_ok ? (MAX_VERTICES'(1) << src_idx) : '0;
			pvalid_q  <= '0;
		end else if (do_apply) begin
			reached_q[ti] <= 1'b1;
			pvalid_q[ti]  <= 1'b1;
		end
	end

	// result read and output register
	logic [VTX_W-1:0] pm_q;
	logic             pv_q;

	always_ff @(posedge clk) begin
		if (cmd.vtx_rd) begin
			pm_q <= pred_mem[v_q];
			pv_q <= pvalid_q[v_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.vtx_ld || cmd.cyc_ld) begin
			out_valid <= 1'b1;
		end else if (m_tready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cyc_ld) begin
			out_vtx  <= '0;
			out_pred <= PRED_NONE;
			out_neg  <= 1'b1;
			out_last <= 1'b1;
		end else if (cmd.vtx_ld) begin
			out_vtx  <= VTX_W'(v_q);
			out_pred <= pv_q ? {1'b0, pm_q} : PRED_NONE;
			out_neg  <= 1'b0;
			out_last <= stat.last_vtx;
		end
	end

	assign stat.out_free = !out_valid || m_tready;

endmodule

/* rtl/bfp_checker.sv */
`timescale 1ns / 1ps
module bfp_checker import bfp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 s_tlast,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser,
	input logic                 m_tlast
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// negative cycle report is the sole item: vertex 0, no predecessor
	a_cycle_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == {{(M_TDATA_W - VTX_W - PRED_W){1'b0}},
			PRED_NONE, {VTX_W{1'b0}}}))
		else $error("malformed negative cycle item");

	// the run starts right after the last edge, so no item is taken then
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("item accepted right after last edge");

	// pad bits above the predecessor stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:VTX_W+PRED_W] == '0)
		else $error("nonzero pad in result item");

endmodule

bind bellman_ford_predecessors bfp_checker u_bfp_checker (.*);
